// ----- src/bptc_pkg.sv -----
// Shared constants and register codes for the barometric compensation block.
// No dependencies; imported by bptc_div and baro_temp_pressure_compensate.
package bptc_pkg;

  // Width of both pipelined dividers, one quotient bit per stage
  localparam int DIV_W = 32;

  typedef enum logic [2:0] {
    CFG_OSS  = 3'd0,
    CFG_AC12 = 3'd1,
    CFG_AC34 = 3'd2,
    CFG_AC56 = 3'd3,
    CFG_B12  = 3'd4,
    CFG_MCMD = 3'd5
  } cfg_idx_t;

  localparam logic [11:0] T_OFFSET  = 12'd4000;
  localparam logic [31:0] U_OFFSET  = 32'd32768;
  localparam logic [15:0] P_SCALE   = 16'd50000;
  localparam logic [11:0] K_SQ      = 12'd3038;
  localparam logic [12:0] K_LIN     = 13'd7357;
  localparam logic [11:0] K_OFS     = 12'd3791;
  localparam logic [17:0] P_MAX     = 18'd262143;
  localparam logic signed [15:0] T_MAX = 16'sh7FFF;
  localparam logic signed [15:0] T_MIN = 16'sh8000;

endpackage

// ----- src/bptc_div.sv -----
// Pipelined unsigned restoring divider, DIV_W stages, one quotient bit each.
// Depends on bptc_pkg. Advances only when en is high.
module bptc_div import bptc_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic [DIV_W-1:0] quo
);

  logic [DIV_W-1:0] rem_s [1:DIV_W];
  logic [DIV_W-1:0] num_s [1:DIV_W];
  logic [DIV_W-1:0] den_s [1:DIV_W];

  for (genvar i = 0; i < DIV_W; i++) begin : g_step
    logic [DIV_W-1:0] rem_in, num_in, den_in;
    logic [DIV_W:0]   part, diff;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_s[i];
      assign num_in = num_s[i];
      assign den_in = den_s[i];
    end

    assign part = {rem_in, num_in[DIV_W-1]};
    assign diff = part - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        den_s[i+1] <= den_in;
        if (!diff[DIV_W]) begin
          rem_s[i+1] <= diff[DIV_W-1:0];
          num_s[i+1] <= {num_in[DIV_W-2:0], 1'b1};
        end else begin
          rem_s[i+1] <= part[DIV_W-1:0];
          num_s[i+1] <= {num_in[DIV_W-2:0], 1'b0};
        end
      end
    end
  end

  // quotient has shifted fully into the numerator word
  assign quo = num_s[DIV_W];

endmodule

// ----- src/baro_temp_pressure_compensate.sv -----
// Top level of the barometric temperature and pressure compensation block.
// Depends on bptc_pkg and bptc_div (two instances).
//
// Takes one item per cycle (raw temperature, raw pressure) and returns one
// item (temperature in 0.1 degC, pressure in Pa, divide fault in tuser)
// through two stages before the temperature divider, 32 divider stages,
// seven stages of pressure terms, 32 divider stages for B7/B4 and four
// stages of final correction and output register. Sustained rate is one
// item per clock; the whole pipeline holds while the output item waits.
// The user must write calibration and oversampling through the cfg port
// only while the pipeline is empty; the block does not enforce this. A
// zero divisor (X1+MD or B4) flags divide_fault and zeroes both results;
// pressure saturates to 0..262143, temperature to the 16-bit signed range.
module baro_temp_pressure_compensate import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [15:0] raw_temperature, [34:16] raw_pressure
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] temperature_tenths, [33:16] pressure_pa
  output logic [0:0]  m_tuser    // [0] divide_fault
);

  // ---------------- configuration ----------------
  logic [1:0]  oss;
  logic [31:0] r_ac12, r_ac34, r_ac56, r_b12, r_mcmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      oss    <= '0;
      r_ac12 <= '0;
      r_ac34 <= '0;
      r_ac56 <= '0;
      r_b12  <= '0;
      r_mcmd <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OSS:  oss    <= cfg_data[1:0];
        CFG_AC12: r_ac12 <= cfg_data;
        CFG_AC34: r_ac34 <= cfg_data;
        CFG_AC56: r_ac56 <= cfg_data;
        CFG_B12:  r_b12  <= cfg_data;
        CFG_MCMD: r_mcmd <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic        [15:0] ac4, ac5, ac6;
  assign ac1 = $signed(r_ac12[31:16]);
  assign ac2 = $signed(r_ac12[15:0]);
  assign ac3 = $signed(r_ac34[31:16]);
  assign ac4 = r_ac34[15:0];
  assign ac5 = r_ac56[31:16];
  assign ac6 = r_ac56[15:0];
  assign b1  = $signed(r_b12[31:16]);
  assign b2  = $signed(r_b12[15:0]);
  assign mc  = $signed(r_mcmd[31:16]);
  assign md  = $signed(r_mcmd[15:0]);

  // whole pipeline advances together; output register frees the way
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- S1: (UT - AC6) * AC5 ----------------
  logic               v1;
  logic signed [33:0] m1;
  logic        [18:0] up1;
  logic signed [16:0] d1;
  assign d1 = $signed({1'b0, s_tdata[15:0]}) - $signed({1'b0, ac6});

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
    if (en) begin
      m1  <= d1 * $signed({1'b0, ac5});
      up1 <= s_tdata[34:16];
    end
  end

  // ---------------- S2: X1, divisor X1 + MD ----------------
  logic               v2;
  logic signed [18:0] x1t2;
  logic signed [19:0] den2;
  logic        [18:0] up2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      x1t2 <= $signed(m1[33:15]);
      den2 <= $signed({m1[33], m1[33:15]}) + $signed({{4{md[15]}}, md});
      up2  <= up1;
    end
  end

  // signed truncating divide done on magnitudes
  logic signed [26:0] tnum;
  logic        [26:0] tnum_mag;
  logic        [19:0] tden_mag;
  logic               tneg, tzero;
  assign tnum     = $signed({mc, 11'b0});
  assign tnum_mag = tnum[26] ? 27'(-tnum) : 27'(tnum);
  assign tden_mag = den2[19] ? 20'(-den2) : 20'(den2);
  assign tneg     = mc[15] ^ den2[19];
  assign tzero    = (den2 == '0);

  logic [DIV_W-1:0] tq;
  bptc_div u_div_t (
    .clk (clk),
    .en  (en),
    .num ({{(DIV_W-27){1'b0}}, tnum_mag}),
    .den (tzero ? DIV_W'(1) : {{(DIV_W-20){1'b0}}, tden_mag}),
    .quo (tq)
  );

  // side data travelling alongside the temperature divider
  logic               dv1   [DIV_W];
  logic signed [18:0] dx1   [DIV_W];
  logic        [18:0] dup   [DIV_W];
  logic               dtz   [DIV_W];
  logic               dneg  [DIV_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_W; k++) dv1[k] <= 1'b0;
    end else if (en) begin
      dv1[0] <= v2;
      for (int k = 1; k < DIV_W; k++) dv1[k] <= dv1[k-1];
    end
    if (en) begin
      dx1[0]  <= x1t2;
      dup[0]  <= up2;
      dtz[0]  <= tzero;
      dneg[0] <= tneg;
      for (int k = 1; k < DIV_W; k++) begin
        dx1[k]  <= dx1[k-1];
        dup[k]  <= dup[k-1];
        dtz[k]  <= dtz[k-1];
        dneg[k] <= dneg[k-1];
      end
    end
  end

  // ---------------- S3: B5 = X1 + X2 ----------------
  logic               v3, tz3;
  logic signed [28:0] b5_3;
  logic        [18:0] up3;
  logic signed [27:0] x2t;
  assign x2t = dneg[DIV_W-1] ? -$signed({1'b0, tq[26:0]}) : $signed({1'b0, tq[26:0]});

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= dv1[DIV_W-1];
    if (en) begin
      b5_3 <= 29'(dx1[DIV_W-1]) + 29'(x2t);
      up3  <= dup[DIV_W-1];
      tz3  <= dtz[DIV_W-1];
    end
  end

  // ---------------- S4: temperature, B6 ----------------
  logic               v4, tz4;
  logic signed [15:0] t4;
  logic signed [29:0] b6_4;
  logic        [18:0] up4;
  logic signed [29:0] tsum;
  logic signed [25:0] tfull;
  logic signed [15:0] tsat;
  assign tsum  = 30'(b5_3) + 30'sd8;
  assign tfull = $signed(tsum[29:4]);
  always_comb begin
    priority if (tfull > 26'(T_MAX)) tsat = T_MAX;
    else if (tfull < 26'(T_MIN))     tsat = T_MIN;
    else                             tsat = tfull[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      t4   <= tsat;
      b6_4 <= 30'(b5_3) - $signed({18'b0, T_OFFSET});
      up4  <= up3;
      tz4  <= tz3;
    end
  end

  // ---------------- S5: B6*B6, AC2*B6, AC3*B6 ----------------
  logic               v5, tz5;
  logic signed [15:0] t5;
  logic        [18:0] up5;
  logic signed [59:0] b6sq5;
  logic signed [45:0] ac2b6_5, ac3b6_5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      b6sq5   <= 60'(b6_4) * 60'(b6_4);
      ac2b6_5 <= 46'(ac2) * 46'(b6_4);
      ac3b6_5 <= 46'(ac3) * 46'(b6_4);
      t5      <= t4;
      up5     <= up4;
      tz5     <= tz4;
    end
  end

  // ---------------- S6: B2*sq, B1*sq ----------------
  logic               v6, tz6;
  logic signed [15:0] t6;
  logic        [18:0] up6;
  logic signed [63:0] b2sq6, b1sq6;
  logic signed [45:0] ac2b6_6, ac3b6_6;
  logic signed [47:0] sq;
  assign sq = $signed(b6sq5[59:12]);

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
    if (en) begin
      b2sq6   <= 64'(b2) * 64'(sq);
      b1sq6   <= 64'(b1) * 64'(sq);
      ac2b6_6 <= ac2b6_5;
      ac3b6_6 <= ac3b6_5;
      t6      <= t5;
      up6     <= up5;
      tz6     <= tz5;
    end
  end

  // ---------------- S7: B3 and X3+32768 (low bits only) ----------------
  // only the low 32 bits of B3 and of X3 survive the mod 2^32 steps later
  logic               v7, tz7;
  logic signed [15:0] t7;
  logic        [18:0] up7;
  logic        [31:0] b3lo7, u7;
  logic        [35:0] wb3, wsh, wrnd;
  logic        [33:0] wx3;
  assign wb3  = b2sq6[46:11] + {ac2b6_6[45], ac2b6_6[45:11]}
              + {{18{ac1[15]}}, ac1, 2'b00};
  assign wsh  = wb3 << oss;
  assign wrnd = wsh + 36'd2;
  assign wx3  = {ac3b6_6[45], ac3b6_6[45:13]} + b1sq6[49:16] + 34'd2;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
    if (en) begin
      b3lo7 <= wrnd[33:2];
      u7    <= wx3[33:2] + U_OFFSET;
      t7    <= t6;
      up7   <= up6;
      tz7   <= tz6;
    end
  end

  // ---------------- S8: B4, UP - B3 ----------------
  logic               v8, tz8;
  logic signed [15:0] t8;
  logic        [16:0] b4_8;
  logic        [31:0] uu8;
  logic        [47:0] b4prod;
  assign b4prod = 48'(ac4) * 48'(u7);

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
    if (en) begin
      b4_8 <= b4prod[31:15];
      uu8  <= {13'b0, up7} - b3lo7;
      t8   <= t7;
      tz8  <= tz7;
    end
  end

  // ---------------- S9: B7, fault ----------------
  logic               v9, fault9;
  logic signed [15:0] t9;
  logic        [16:0] b4_9;
  logic        [31:0] b7_9;
  logic        [47:0] b7prod;
  assign b7prod = 48'(uu8) * 48'(P_SCALE >> oss);

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
    if (en) begin
      b7_9   <= b7prod[31:0];
      b4_9   <= b4_8;
      t9     <= t8;
      fault9 <= tz8 || (b4_8 == '0);
    end
  end

  // B7 with top bit set divides unshifted and doubles the quotient
  logic             phi;
  logic [DIV_W-1:0] pq;
  assign phi = b7_9[31];

  bptc_div u_div_p (
    .clk (clk),
    .en  (en),
    .num (phi ? b7_9 : {b7_9[30:0], 1'b0}),
    .den ((b4_9 == '0) ? DIV_W'(1) : {{(DIV_W-17){1'b0}}, b4_9}),
    .quo (pq)
  );

  logic               ev  [DIV_W];
  logic signed [15:0] et  [DIV_W];
  logic               ef  [DIV_W];
  logic               ehi [DIV_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_W; k++) ev[k] <= 1'b0;
    end else if (en) begin
      ev[0] <= v9;
      for (int k = 1; k < DIV_W; k++) ev[k] <= ev[k-1];
    end
    if (en) begin
      et[0]  <= t9;
      ef[0]  <= fault9;
      ehi[0] <= phi;
      for (int k = 1; k < DIV_W; k++) begin
        et[k]  <= et[k-1];
        ef[k]  <= ef[k-1];
        ehi[k] <= ehi[k-1];
      end
    end
  end

  // ---------------- S10: p ----------------
  logic               v10, f10;
  logic signed [15:0] t10;
  logic        [32:0] p10;

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= ev[DIV_W-1];
    if (en) begin
      p10 <= ehi[DIV_W-1] ? {pq, 1'b0} : {1'b0, pq};
      t10 <= et[DIV_W-1];
      f10 <= ef[DIV_W-1];
    end
  end

  // ---------------- S11: (p>>8)^2, 7357*p ----------------
  logic               v11, f11;
  logic signed [15:0] t11;
  logic        [32:0] p11;
  logic        [49:0] sqp11;
  logic        [45:0] x2m11;

  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= v10;
    if (en) begin
      sqp11 <= 50'(p10[32:8]) * 50'(p10[32:8]);
      x2m11 <= 46'(p10) * 46'(K_LIN);
      p11   <= p10;
      t11   <= t10;
      f11   <= f10;
    end
  end

  // ---------------- S12: X1 * 3038 ----------------
  logic               v12, f12;
  logic signed [15:0] t12;
  logic        [32:0] p12;
  logic        [61:0] m12;
  logic        [45:0] x2m12;

  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (en) v12 <= v11;
    if (en) begin
      m12   <= 62'(sqp11) * 62'(K_SQ);
      x2m12 <= x2m11;
      p12   <= p11;
      t12   <= t11;
      f12   <= f11;
    end
  end

  // ---------------- output: correction, saturation ----------------
  logic signed [46:0] x2neg;
  logic signed [47:0] csum;
  logic signed [49:0] pfin;
  logic        [17:0] psat;
  assign x2neg = -$signed({1'b0, x2m12});
  assign csum  = $signed({2'b00, m12[61:16]}) + 48'($signed(x2neg[46:16]))
               + $signed({36'b0, K_OFS});
  assign pfin  = $signed({17'b0, p12}) + 50'($signed(csum[47:4]));
  always_comb begin
    priority if (pfin[49])          psat = '0;
    else if (pfin > 50'(P_MAX))     psat = P_MAX;
    else                            psat = pfin[17:0];
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= v12;
    if (en) begin
      m_tdata[39:34] <= '0;
      m_tdata[33:16] <= f12 ? '0 : psat;
      m_tdata[15:0]  <= f12 ? '0 : t12;
      m_tuser[0]     <= f12;
    end
  end

  // ---------------- checks ----------------
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[33:0] == '0))
    else $error("fault item carries nonzero results");

  a_b4_fault: assert property (@(posedge clk) disable iff (rst)
    (v9 && (b4_9 == '0)) |-> fault9)
    else $error("zero B4 not flagged");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(v12) && $stable(p12)))
    else $error("last stage moved while stalled");

endmodule
